// ----- hdl/tua_pkg.sv -----
// ----------------------------------------------------------------------------
// tua_pkg
// Shared widths and types for the triangle absolute unit normal block.
// ----------------------------------------------------------------------------
package tua_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int OUT_FRAC_BITS = 16;

  // edge, cross magnitude, half split, square, sum of squares
  localparam int EW   = COORD_WIDTH + 1;
  localparam int PW   = 2 * EW;
  localparam int NW   = 2 * EW;
  localparam int HW   = NW / 2;
  localparam int LW   = NW - HW;
  localparam int SQW  = 2 * NW;
  localparam int SW   = SQW + 2;
  // signed residual width for the digit chain
  localparam int RW   = SW + 2 * OUT_FRAC_BITS + 5;
  localparam int QW   = OUT_FRAC_BITS + 1;
  localparam int NCELL = OUT_FRAC_BITS + 1;
  localparam int BPW  = $clog2(NCELL + 1);
  // cycles from the accepting edge to the strobe
  localparam int LATENCY = NCELL + 7;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // one item as it moves down the chain of digit cells
  typedef struct packed {
    logic                   vld;
    logic                   degen;
    logic [SW-1:0]          s;
    logic [2:0][RW-1:0]     e;
    logic [2:0][RW-1:0]     t;
    logic [2:0][QW-1:0]     q;
  } cell_data_t;

endpackage

// ----- hdl/tua_front.sv -----
// ----------------------------------------------------------------------------
// tua_front
// Edges, cross product magnitudes, squares and the sum of squares; seeds the
// digit chain with its starting residuals.
// ----------------------------------------------------------------------------
module tua_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  tua_pkg::coord_t     v [9],
  output tua_pkg::cell_data_t seed
);
  import tua_pkg::*;

  logic [4:0] vld_r;
  logic signed [EW-1:0] e_r [6];
  logic signed [PW-1:0] p_r [6];
  logic [NW-1:0]        n_r [3];
  logic [2*HW-1:0]      hh_r [3];
  logic [2*HW-1:0]      hl_r [3];
  logic [2*LW-1:0]      ll_r [3];
  logic [SQW-1:0]       sq_r [3];
  cell_data_t           seed_r;

  logic signed [PW:0]   diff [3];
  logic [PW:0]          dabs [3];
  logic [SQW-1:0]       sq_nxt [3];
  logic [SW-1:0]        s_sum;
  cell_data_t           seed_nxt;

  // valid pipe, one bit per data stage ahead of the seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  // edges: e0 = v1 - v0, e1 = v2 - v0
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e_r[i]   <= EW'(v[3+i]) - EW'(v[i]);
      e_r[3+i] <= EW'(v[6+i]) - EW'(v[i]);
    end
  end

  // cross product partial products (x, y, z pairs)
  always_ff @(posedge clk) begin
    p_r[0] <= PW'(e_r[1]) * PW'(e_r[5]);
    p_r[1] <= PW'(e_r[2]) * PW'(e_r[4]);
    p_r[2] <= PW'(e_r[2]) * PW'(e_r[3]);
    p_r[3] <= PW'(e_r[0]) * PW'(e_r[5]);
    p_r[4] <= PW'(e_r[0]) * PW'(e_r[4]);
    p_r[5] <= PW'(e_r[1]) * PW'(e_r[3]);
  end

  // absolute cross components
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = (PW+1)'(p_r[2*i]) - (PW+1)'(p_r[2*i+1]);
      dabs[i] = diff[i][PW] ? (PW+1)'(-diff[i]) : (PW+1)'(diff[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) n_r[i] <= dabs[i][NW-1:0];
  end

  // squares split into half-width products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      hh_r[i] <= (2*HW)'(n_r[i][NW-1:LW]) * (2*HW)'(n_r[i][NW-1:LW]);
      hl_r[i] <= (2*HW)'(n_r[i][NW-1:LW]) * (2*HW)'(n_r[i][LW-1:0]);
      ll_r[i] <= (2*LW)'(n_r[i][LW-1:0]) * (2*LW)'(n_r[i][LW-1:0]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = (SQW'(hh_r[i]) << (2*LW)) + (SQW'(hl_r[i]) << (LW+1)) + SQW'(ll_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) sq_r[i] <= sq_nxt[i];
  end

  // sum of squares and starting residuals: E = R - S, T = -S
  always_comb begin
    s_sum = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
    seed_nxt.vld   = vld_r[4];
    seed_nxt.degen = (s_sum == '0);
    seed_nxt.s     = s_sum;
    for (int i = 0; i < 3; i++) begin
      seed_nxt.e[i] = (RW'(sq_r[i]) << (2*OUT_FRAC_BITS+2)) - RW'(s_sum);
      seed_nxt.t[i] = RW'(0) - RW'(s_sum);
      seed_nxt.q[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r.vld <= 1'b0;
    end else begin
      seed_r.vld <= seed_nxt.vld;
    end
    seed_r.degen <= seed_nxt.degen;
    seed_r.s     <= seed_nxt.s;
    seed_r.e     <= seed_nxt.e;
    seed_r.t     <= seed_nxt.t;
    seed_r.q     <= seed_nxt.q;
  end

  assign seed = seed_r;

endmodule

// ----- hdl/tua_cell.sv -----
// ----------------------------------------------------------------------------
// tua_cell
// One result bit per component: trial of the squared round-to-nearest test,
// updated incrementally with shifts and adds.
// ----------------------------------------------------------------------------
module tua_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [tua_pkg::BPW-1:0] bit_pos,
  input  tua_pkg::cell_data_t    d_in,
  output tua_pkg::cell_data_t    d_out
);
  import tua_pkg::*;

  cell_data_t        d_r;
  cell_data_t        d_nxt;
  logic [RW-1:0]     s_ext;
  logic [RW-1:0]     trial [3];

  // try setting this bit; keep it when the residual stays non-negative
  always_comb begin
    s_ext = RW'(d_in.s);
    d_nxt = d_in;
    for (int i = 0; i < 3; i++) begin
      trial[i] = d_in.e[i] - (d_in.t[i] << (bit_pos + 2)) - (s_ext << (2*bit_pos + 2));
      if (!trial[i][RW-1]) begin
        d_nxt.e[i] = trial[i];
        d_nxt.t[i] = d_in.t[i] + (s_ext << (bit_pos + 1));
        d_nxt.q[i] = d_in.q[i] | (QW'(1) << bit_pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else begin
      d_r.vld <= d_nxt.vld;
    end
    d_r.degen <= d_nxt.degen;
    d_r.s     <= d_nxt.s;
    d_r.e     <= d_nxt.e;
    d_r.t     <= d_nxt.t;
    d_r.q     <= d_nxt.q;
  end

  assign d_out = d_r;

endmodule

// ----- hdl/triangle_abs_unit_normal_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_abs_unit_normal_unit
// Absolute unit normal of a triangle, rounded to nearest, unsigned Q1.16.
// ----------------------------------------------------------------------------
// A triangle is taken on every cycle (busy stays low) and its result strobes
// out_valid in input order, after a six-stage front end of edges, cross
// products and squares, the chain of digit cells, one per result bit, and the
// output register. Results cannot be held off: capture them on the strobe
// cycle. A zero cross product gives zero components with out_degenerate high.
module triangle_abs_unit_normal_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tua_pkg::COORD_WIDTH-1:0] in_v0_x,
  input  logic [tua_pkg::COORD_WIDTH-1:0] in_v0_y,
  input  logic [tua_pkg::COORD_WIDTH-1:0] in_v0_z,
  input  logic [tua_pkg::COORD_WIDTH-1:0] in_v1_x,
  input  logic [tua_pkg::COORD_WIDTH-1:0] in_v1_y,
  input  logic [tua_pkg::COORD_WIDTH-1:0] in_v1_z,
  input  logic [tua_pkg::COORD_WIDTH-1:0] in_v2_x,
  input  logic [tua_pkg::COORD_WIDTH-1:0] in_v2_y,
  input  logic [tua_pkg::COORD_WIDTH-1:0] in_v2_z,
  output logic                          out_valid,
  output logic [tua_pkg::QW-1:0]        out_norm_x,
  output logic [tua_pkg::QW-1:0]        out_norm_y,
  output logic [tua_pkg::QW-1:0]        out_norm_z,
  output logic                          out_degenerate
);
  import tua_pkg::*;

  coord_t      v [9];
  cell_data_t  chain [NCELL+1];
  logic        out_valid_r;
  logic [QW-1:0] nx_r, ny_r, nz_r;
  logic        degen_r;

  assign busy = 1'b0;

  assign v[0] = in_v0_x;
  assign v[1] = in_v0_y;
  assign v[2] = in_v0_z;
  assign v[3] = in_v1_x;
  assign v[4] = in_v1_y;
  assign v[5] = in_v1_z;
  assign v[6] = in_v2_x;
  assign v[7] = in_v2_y;
  assign v[8] = in_v2_z;

  tua_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (start && !busy),
    .v      (v),
    .seed   (chain[0])
  );

  // one cell per result bit, most significant first
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    tua_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .bit_pos (BPW'(NCELL - 1 - k)),
      .d_in    (chain[k]),
      .d_out   (chain[k+1])
    );
  end

  // output register; drop components of a degenerate triangle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[NCELL].vld;
    end
    degen_r <= chain[NCELL].degen;
    nx_r    <= chain[NCELL].degen ? '0 : chain[NCELL].q[0];
    ny_r    <= chain[NCELL].degen ? '0 : chain[NCELL].q[1];
    nz_r    <= chain[NCELL].degen ? '0 : chain[NCELL].q[2];
  end

  assign out_valid      = out_valid_r;
  assign out_norm_x     = nx_r;
  assign out_norm_y     = ny_r;
  assign out_norm_z     = nz_r;
  assign out_degenerate = degen_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LATENCY out_valid)
    else $error("item lost in pipeline");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_norm_x <= (QW'(1) << OUT_FRAC_BITS)) &&
                  (out_norm_y <= (QW'(1) << OUT_FRAC_BITS)) &&
                  (out_norm_z <= (QW'(1) << OUT_FRAC_BITS)))
    else $error("component above one");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_degenerate) |->
      (out_norm_x != '0) || (out_norm_y != '0) || (out_norm_z != '0))
    else $error("non-degenerate normal with all components zero");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("strobe right after reset");

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the triangle absolute unit normal block: directed
// and random triangles are driven under random start gaps, each result is
// predicted exactly with wide integer math and compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tua_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int FB = OUT_FRAC_BITS;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [CW-1:0] v [9];
  } tri_t;

  typedef struct {
    logic [QW-1:0] nx;
    logic [QW-1:0] ny;
    logic [QW-1:0] nz;
    logic          degen;
  } unit_normal_t;

  logic clk;
  logic rst_n;
  logic start = 1'b0;
  logic busy;
  logic [CW-1:0] in_v [9] = '{default: '0};
  logic out_valid;
  logic [QW-1:0] out_norm_x, out_norm_y, out_norm_z;
  logic out_degenerate;

  tri_t         tri_q[$];
  unit_normal_t normal_q[$];
  int  errors = 0;
  int  cycles = 0;
  int  gap;
  bit  stim_done;

  triangle_abs_unit_normal_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_v0_x(in_v[0]), .in_v0_y(in_v[1]), .in_v0_z(in_v[2]),
    .in_v1_x(in_v[3]), .in_v1_y(in_v[4]), .in_v1_z(in_v[5]),
    .in_v2_x(in_v[6]), .in_v2_y(in_v[7]), .in_v2_z(in_v[8]),
    .out_valid(out_valid), .out_norm_x(out_norm_x), .out_norm_y(out_norm_y),
    .out_norm_z(out_norm_z), .out_degenerate(out_degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Round |c| * 2^FB / |n| to nearest: largest q with (2q-1)^2*s <= 4*c^2*2^(2FB)
  function automatic logic [QW-1:0] unit_component(logic signed [127:0] c,
                                                   logic [255:0] s);
    logic [255:0] rhs;
    logic [255:0] lhs;
    logic [QW-1:0] q;
    logic [QW-1:0] cand;
    logic [63:0] odd;
    if (c < 0) c = -c;
    rhs = (256'(c) * 256'(c)) << (2 * FB + 2);
    q = '0;
    for (int b = FB; b >= 0; b--) begin
      cand = q | (QW'(1) << b);
      odd = 64'(2 * cand - 1);
      lhs = s * 256'(odd * odd);
      if (lhs <= rhs) q = cand;
    end
    return q;
  endfunction

  function automatic unit_normal_t predict_normal(tri_t t);
    logic signed [63:0] p [9];
    logic signed [63:0] e0 [3];
    logic signed [63:0] e1 [3];
    logic signed [127:0] n [3];
    logic [255:0] s;
    unit_normal_t r;
    for (int i = 0; i < 9; i++) p[i] = 64'($signed(t.v[i]));
    for (int i = 0; i < 3; i++) begin
      e0[i] = p[3 + i] - p[i];
      e1[i] = p[6 + i] - p[i];
    end
    n[0] = 128'(e0[1]) * 128'(e1[2]) - 128'(e0[2]) * 128'(e1[1]);
    n[1] = 128'(e0[2]) * 128'(e1[0]) - 128'(e0[0]) * 128'(e1[2]);
    n[2] = 128'(e0[0]) * 128'(e1[1]) - 128'(e0[1]) * 128'(e1[0]);
    s = '0;
    for (int i = 0; i < 3; i++) s += 256'(n[i] * n[i]);
    if (s == 0) begin
      r = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
    end else begin
      r.nx = unit_component(n[0], s);
      r.ny = unit_component(n[1], s);
      r.nz = unit_component(n[2], s);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return CW'($urandom);
      1: return CW'($urandom_range(0, 64) - 32);
      default: return CW'($urandom_range(0, 8192) - 4096);
    endcase
  endfunction

  task automatic push_tri(logic [CW-1:0] a [9]);
    tri_t t;
    t.v = a;
    tri_q.push_back(t);
  endtask

  // Fill the item queue: directed corners first, then random triangles
  initial begin
    logic [CW-1:0] a [9];
    logic [CW-1:0] mx, mn;
    int mode;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    a = '{default: '0};
    push_tri(a);                                         // all zero: degenerate
    a = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0}; push_tri(a); // unit xy triangle
    a = '{0, 0, 0, 0, 4096, 0, 0, 0, 4096}; push_tri(a);
    a = '{0, 0, 0, 0, 0, 4096, 4096, 0, 0}; push_tri(a);
    a = '{0, 0, 0, 1, 1, 1, 2, 2, 2};       push_tri(a); // collinear
    a = '{5, 5, 5, 5, 5, 5, 9, 1, 3};       push_tri(a); // repeated vertex
    a = '{mn, mn, mn, mx, mn, mn, mn, mx, mn}; push_tri(a);
    a = '{mx, mx, mx, mn, mx, mx, mx, mn, mx}; push_tri(a);
    a = '{mn, mx, mn, mx, mn, mx, mx, mx, mn}; push_tri(a);
    a = '{mx, mn, mx, mn, mn, mx, mn, mx, mx}; push_tri(a);
    a = '{mn, mn, mn, mx, mx, mn, mn, mx, mx}; push_tri(a);
    a = '{0, 0, 0, 1, 0, 0, 0, 1, 1};       push_tri(a); // diagonal
    a = '{0, 0, 0, 1, 2, 0, 2, 1, 0};       push_tri(a);
    a = '{0, 0, 0, 3, 0, 0, 0, 4, 5};       push_tri(a);
    a = '{default: mx}; push_tri(a);
    a = '{default: mn}; push_tri(a);
    for (int k = 0; k < 400; k++) begin
      mode = $urandom_range(0, 2);
      for (int i = 0; i < 9; i++) a[i] = rand_coord(mode);
      // now and then place v2 at 2*v1 - v0, collinear unless a coordinate wraps
      if ($urandom_range(0, 15) == 0)
        for (int i = 0; i < 3; i++) a[6 + i] = a[3 + i] + (a[3 + i] - a[i]);
      push_tri(a);
    end
  end

  // Drive start after a random gap per item; accept on start && !busy
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      stim_done <= 1'b0;
      gap <= $urandom_range(0, 9);
    end else if (start && busy) begin
      start <= 1'b1;
    end else if (gap > 0 || tri_q.size() == 0) begin
      if (start) begin
        normal_q.push_back(predict_normal(tri_q.pop_front()));
        gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        if (tri_q.size() == 0) stim_done <= 1'b1;
      end else if (gap > 0) begin
        gap <= gap - 1;
      end
      start <= 1'b0;
    end else if (start) begin
      // item accepted; next one goes back to back
      normal_q.push_back(predict_normal(tri_q.pop_front()));
      if (tri_q.size() > 0) begin
        in_v <= tri_q[0].v;
        gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        start <= 1'b1;
      end else begin
        stim_done <= 1'b1;
        start <= 1'b0;
      end
    end else begin
      in_v <= tri_q[0].v;
      start <= 1'b1;
    end
  end

  // Compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    unit_normal_t exp_n;
    if (rst_n && out_valid) begin
      if (normal_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result at cycle %0d", cycles);
      end else begin
        exp_n = normal_q.pop_front();
        if (exp_n.nx !== out_norm_x || exp_n.ny !== out_norm_y ||
            exp_n.nz !== out_norm_z || exp_n.degen !== out_degenerate) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: normal exp %h %h %h d%b got %h %h %h d%b",
                     exp_n.nx, exp_n.ny, exp_n.nz, exp_n.degen,
                     out_norm_x, out_norm_y, out_norm_z, out_degenerate);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (!(stim_done && normal_q.size() == 0) && cycles < CYCLE_LIMIT)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
    end else if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Count cycles for the run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

endmodule

// ----- sim.f -----
hdl/tua_pkg.sv
hdl/tua_front.sv
hdl/tua_cell.sv
hdl/triangle_abs_unit_normal_unit.sv
bench/tb_top.sv
